// ===== hw/rtl/hsgt_pkg.sv =====
package hsgt_pkg;

    localparam int TableDepthDef = 64;
    localparam int StaleTicksDef = 10;

    localparam logic [12:0] OneQ12 = 13'd4096;

    typedef enum logic [1:0] {
        CMD_SURPRISE = 2'd0,
        CMD_LEARN    = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_QUERY    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        REG_LR_GAIN    = 3'd0,
        REG_HAB_STEP   = 3'd1,
        REG_RECOVERY   = 3'd2,
        REG_STDP_GAIN  = 3'd3,
        REG_ELIG_GAIN  = 3'd4,
        REG_BCM_GAIN   = 3'd5,
        REG_THRESHOLD  = 3'd6,
        REG_DECAY      = 3'd7
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DROP_M,
        S_DROP_W,
        S_SCAN,
        S_LAST,
        S_EFF_M,
        S_EFF_W,
        S_LRN_M,
        S_LRN_W,
        S_BST,
        S_DEC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [31:0] key;
        logic [12:0] hab;
        logic [31:0] last;
    } t_entry;

    // Saturate a value to 16 bits, negative values clamping to zero.
    function automatic logic [15:0] f_sat16(input logic signed [37:0] v);
        logic [15:0] r;
        if (v < 0) begin
            r = 16'd0;
        end else if (v > 38'sd65535) begin
            r = 16'hFFFF;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // 1 + e * (g - 1), from the product e * g.
    function automatic logic [15:0] f_boost(input logic signed [35:0] p,
                                            input logic [12:0] e);
        logic signed [37:0] s;
        s = 38'(p) + 38'(signed'({13'd0, (OneQ12 - e), 12'd0})) + 38'sd2048;
        return f_sat16(s >>> 12);
    endfunction

    // 1 + floor((dev * decay + 2048) / 4096), from the product dev * decay.
    function automatic logic [15:0] f_decay(input logic signed [35:0] p);
        logic signed [37:0] s;
        s = ((38'(p) + 38'sd2048) >>> 12) + 38'sd4096;
        return f_sat16(s);
    endfunction

    // Rounded Q4.12 product, saturated to 16 bits.
    function automatic logic [15:0] f_q12(input logic signed [35:0] p);
        logic signed [37:0] s;
        s = (38'(p) + 38'sd2048) >>> 12;
        return f_sat16(s);
    endfunction

endpackage

// ===== hw/rtl/hsgt_if.sv =====
interface hsgt_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [31:0]        source_key;
    logic signed [15:0] signed_value;
    logic [15:0]        delta_time;

    modport source (output valid, cmd, source_key, signed_value, delta_time, input ready);
    modport sink (input valid, cmd, source_key, signed_value, delta_time, output ready);
endinterface

interface hsgt_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] learn_rate_gain;
    logic [15:0] timing_window_gain;
    logic [15:0] trace_multiplier;
    logic [15:0] bcm_offset;
    logic [12:0] source_habituation;
    logic [12:0] effective_level;
    logic        boosted;
    logic        source_known;
    logic [6:0]  tracked_count;

    modport source (output valid, learn_rate_gain, timing_window_gain, trace_multiplier,
                    bcm_offset, source_habituation, effective_level, boosted,
                    source_known, tracked_count, input ready);
    modport sink (input valid, learn_rate_gain, timing_window_gain, trace_multiplier,
                  bcm_offset, source_habituation, effective_level, boosted,
                  source_known, tracked_count, output ready);
endinterface

interface hsgt_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/hsgt_mul.sv =====
module hsgt_mul
    import hsgt_pkg::*;
(
    input  logic               i_clk,
    input  logic signed [17:0] i_a,
    input  logic signed [17:0] i_b,
    output logic signed [35:0] o_p
);

    logic signed [35:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ===== hw/rtl/hsgt_table.sv =====
module hsgt_table
    import hsgt_pkg::*;
#(
    parameter int TABLE_DEPTH = TableDepthDef,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/habituating_surprise_gain_table_top.sv =====
// Channel    Dir   Handshake          Payload
// i_in       in    valid / ready      cmd, source_key, signed_value, delta_time
// o_out      out   valid / ready      four effects, habituation, level, flags, count
// i_cfg      in    valid / ready      index (3 bits), data (16 bits)
//
// Each transaction walks all occupied table entries through the table's read port
// (it has one read and one write port), then one shared multiplier serves up to five
// products in turn. Reset is synchronous and active low; the table itself is not
// cleared, as only occupied entries are ever read. A result waits in the output
// register while the next transaction is taken; the sequencer stalls only when it
// finishes with that register still full.
module habituating_surprise_gain_table_top
    import hsgt_pkg::*;
#(
    parameter int TABLE_DEPTH = TableDepthDef,
    parameter int STALE_TICKS = StaleTicksDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hsgt_in_if.sink     i_in,
    hsgt_out_if.source  o_out,
    hsgt_cfg_if.sink    i_cfg
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] Depth = CW'(TABLE_DEPTH);
    localparam logic [31:0]   Stale = 32'(STALE_TICKS);

    // Configuration registers.
    logic [15:0] r_lr_gain, r_stdp_gain, r_elig_gain, r_bcm_gain;
    logic [12:0] r_step, r_recovery, r_threshold, r_decay;

    // Sequencer and transaction state.
    t_state      r_state, n_state;
    t_cmd        r_cmd;
    logic [31:0] r_key;
    logic signed [15:0] r_sval;
    logic [15:0] r_dt;
    logic [CW-1:0] r_idx, n_idx;
    logic        r_rd_vld, n_rd_vld;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic        r_found, n_found;
    logic [AW-1:0] r_fidx, n_fidx;
    logic [12:0] r_fhab, n_fhab;
    logic [31:0] r_flast, n_flast;
    logic [AW-1:0] r_minidx, n_minidx;
    logic [31:0] r_minlast, n_minlast;
    logic [21:0] r_drop, n_drop;
    logic [AW-1:0] r_tidx, n_tidx;
    logic        r_tnew, n_tnew;
    logic [12:0] r_thab, n_thab;
    logic [12:0] r_eff, n_eff;
    logic        r_boost, n_boost;
    logic [2:0]  r_k, n_k;

    // Architectural state.
    logic [CW-1:0] r_count, n_count;
    logic [31:0] r_tick, n_tick;
    logic [15:0] r_elr, n_elr, r_estdp, n_estdp, r_etrace, n_etrace, r_ebcm, n_ebcm;

    // Output register.
    logic        r_out_vld, n_out_vld;
    logic [15:0] r_o_lr, r_o_stdp, r_o_trace, r_o_bcm;
    logic [12:0] r_o_hab, r_o_eff;
    logic        r_o_boost, r_o_known;
    logic [6:0]  r_o_count;
    logic        load_out;

    // Table and multiplier ports.
    logic          tbl_we;
    logic [AW-1:0] tbl_waddr, tbl_raddr;
    t_entry        tbl_wdata, tbl_rdata;
    logic signed [17:0] mul_a, mul_b;
    logic signed [35:0] mul_p;

    logic        accept;
    logic [12:0] level;
    logic [16:0] mag;
    logic        tick_live;
    logic [31:0] age;
    logic [12:0] scan_hab;
    logic [13:0] hab_sum;
    logic [17:0] lrn_sum;
    logic [16:0] inc;
    logic [12:0] cur_thab;
    logic [15:0] dec_src;

    hsgt_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    hsgt_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign accept      = i_in.valid && i_in.ready;
    assign load_out    = (r_state == S_DONE) && (!r_out_vld || o_out.ready);

    assign o_out.valid              = r_out_vld;
    assign o_out.learn_rate_gain    = r_o_lr;
    assign o_out.timing_window_gain = r_o_stdp;
    assign o_out.trace_multiplier   = r_o_trace;
    assign o_out.bcm_offset         = r_o_bcm;
    assign o_out.source_habituation = r_o_hab;
    assign o_out.effective_level    = r_o_eff;
    assign o_out.boosted            = r_o_boost;
    assign o_out.source_known       = r_o_known;
    assign o_out.tracked_count      = r_o_count;

    // Surprise level clamped to 0..1 and the magnitude of a weight change.
    always_comb begin
        if (r_sval < 0) begin
            level = 13'd0;
        end else if (r_sval > 16'sd4096) begin
            level = OneQ12;
        end else begin
            level = r_sval[12:0];
        end
        mag = r_sval[15] ? 17'(-18'(r_sval)) : 17'(r_sval);
    end

    // A tick with a zero duration leaves the table untouched.
    assign tick_live = (r_cmd == CMD_TICK) && (r_dt != 16'd0);
    assign age       = r_tick - tbl_rdata.last;

    always_comb begin
        if (tick_live && (age > Stale)) begin
            scan_hab = (22'(tbl_rdata.hab) > r_drop) ? 13'(22'(tbl_rdata.hab) - r_drop)
                                                      : 13'd0;
        end else begin
            scan_hab = tbl_rdata.hab;
        end
    end

    assign cur_thab = r_found ? r_fhab : 13'd0;
    assign hab_sum  = 14'(r_thab) + 14'(r_step);
    assign inc      = 17'((mul_p + 36'sd2048) >>> 12);
    assign lrn_sum  = 18'(r_fhab) + 18'(inc);

    always_comb begin
        unique case (r_k[1:0])
            2'd0:    dec_src = r_elr;
            2'd1:    dec_src = r_estdp;
            2'd2:    dec_src = r_etrace;
            default: dec_src = r_ebcm;
        endcase
    end

    // Operands of the shared multiplier for the step in progress.
    always_comb begin
        mul_a = 18'sd0;
        mul_b = 18'sd0;
        unique case (r_state)
            S_DROP_M: begin
                mul_a = signed'({5'd0, r_recovery});
                mul_b = signed'({2'd0, r_dt});
            end
            S_EFF_M: begin
                mul_a = signed'({5'd0, level});
                mul_b = signed'({5'd0, OneQ12 - cur_thab});
            end
            S_LRN_M: begin
                mul_a = signed'({1'b0, mag});
                mul_b = signed'({5'd0, r_step});
            end
            S_BST: begin
                mul_a = signed'({5'd0, r_eff});
                unique case (r_k[1:0])
                    2'd0:    mul_b = signed'({2'd0, r_lr_gain});
                    2'd1:    mul_b = signed'({2'd0, r_stdp_gain});
                    2'd2:    mul_b = signed'({2'd0, r_elig_gain});
                    default: mul_b = signed'({2'd0, r_bcm_gain});
                endcase
            end
            S_DEC: begin
                if (r_k == 3'd3) begin
                    mul_a = signed'({2'd0, dec_src});
                end else begin
                    mul_a = signed'({2'd0, dec_src}) - 18'sd4096;
                end
                mul_b = signed'({5'd0, r_decay});
            end
            default: begin
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (t_cmd'(i_in.cmd) == CMD_TICK) ? S_DROP_M : S_SCAN;
                end
            end
            S_DROP_M: n_state = S_DROP_W;
            S_DROP_W: n_state = S_SCAN;
            S_SCAN: begin
                if (r_idx == r_count) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                unique case (r_cmd)
                    CMD_SURPRISE: n_state = S_EFF_M;
                    CMD_LEARN:    n_state = n_found ? S_LRN_M : S_DONE;
                    CMD_TICK:     n_state = tick_live ? S_DEC : S_DONE;
                    default:      n_state = S_DONE;
                endcase
            end
            S_EFF_M: n_state = S_EFF_W;
            S_EFF_W: begin
                n_state = (n_eff >= r_threshold) ? S_BST : S_DONE;
            end
            S_LRN_M: n_state = S_LRN_W;
            S_LRN_W: n_state = S_DONE;
            S_BST, S_DEC: begin
                if (r_k == 3'd4) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and table accesses.
    always_comb begin
        n_idx     = r_idx;
        n_rd_vld  = 1'b0;
        n_rd_idx  = r_rd_idx;
        n_found   = r_found;
        n_fidx    = r_fidx;
        n_fhab    = r_fhab;
        n_flast   = r_flast;
        n_minidx  = r_minidx;
        n_minlast = r_minlast;
        n_drop    = r_drop;
        n_tidx    = r_tidx;
        n_tnew    = r_tnew;
        n_thab    = r_thab;
        n_eff     = r_eff;
        n_boost   = r_boost;
        n_k       = r_k;
        n_count   = r_count;
        n_tick    = r_tick;
        n_elr     = r_elr;
        n_estdp   = r_estdp;
        n_etrace  = r_etrace;
        n_ebcm    = r_ebcm;
        tbl_we    = 1'b0;
        tbl_waddr = r_rd_idx;
        tbl_wdata = tbl_rdata;
        tbl_raddr = r_idx[AW-1:0];

        if (accept) begin
            n_idx   = '0;
            n_found = 1'b0;
            n_eff   = 13'd0;
            n_boost = 1'b0;
            n_drop  = 22'd0;
        end

        // Read data of the previous scan address: match, oldest entry, recovery.
        if (r_rd_vld) begin
            if (!r_found && (tbl_rdata.key == r_key)) begin
                n_found = 1'b1;
                n_fidx  = r_rd_idx;
                n_fhab  = scan_hab;
                n_flast = tbl_rdata.last;
            end
            if ((r_rd_idx == '0) || (tbl_rdata.last < r_minlast)) begin
                n_minidx  = r_rd_idx;
                n_minlast = tbl_rdata.last;
            end
            if (tick_live) begin
                tbl_we        = 1'b1;
                tbl_waddr     = r_rd_idx;
                tbl_wdata.hab = scan_hab;
            end
        end

        unique case (r_state)
            S_DROP_W: begin
                n_drop = 22'((mul_p + 36'sd128) >>> 8);
            end
            S_SCAN: begin
                if (r_idx != r_count) begin
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_idx[AW-1:0];
                    n_idx    = r_idx + 1'b1;
                end
            end
            S_EFF_M: begin
                n_thab = cur_thab;
                n_tnew = !r_found;
                if (r_found) begin
                    n_tidx = r_fidx;
                end else if (r_count < Depth) begin
                    n_tidx = r_count[AW-1:0];
                end else begin
                    n_tidx = r_minidx;
                end
            end
            S_EFF_W: begin
                n_eff     = 13'((mul_p + 36'sd2048) >>> 12);
                n_fhab    = (hab_sum > 14'(OneQ12)) ? OneQ12 : hab_sum[12:0];
                tbl_we    = 1'b1;
                tbl_waddr = r_tidx;
                tbl_wdata = '{key: r_key, hab: n_fhab, last: r_tick};
                if (r_tnew && (r_count < Depth)) begin
                    n_count = r_count + 1'b1;
                end
                n_k = 3'd0;
            end
            S_LRN_W: begin
                n_fhab    = (lrn_sum > 18'(OneQ12)) ? OneQ12 : lrn_sum[12:0];
                tbl_we    = 1'b1;
                tbl_waddr = r_fidx;
                tbl_wdata = '{key: r_key, hab: n_fhab, last: r_flast};
            end
            S_LAST: begin
                n_k = 3'd0;
            end
            S_BST: begin
                n_k = r_k + 1'b1;
                unique case (r_k)
                    3'd1:    n_elr    = f_boost(mul_p, r_eff);
                    3'd2:    n_estdp  = f_boost(mul_p, r_eff);
                    3'd3:    n_etrace = f_boost(mul_p, r_eff);
                    3'd4: begin
                        n_ebcm  = f_q12(mul_p);
                        n_boost = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_DEC: begin
                n_k = r_k + 1'b1;
                unique case (r_k)
                    3'd1:    n_elr    = f_decay(mul_p);
                    3'd2:    n_estdp  = f_decay(mul_p);
                    3'd3:    n_etrace = f_decay(mul_p);
                    3'd4: begin
                        n_ebcm = f_q12(mul_p);
                        n_tick = r_tick + 32'd1;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (load_out) begin
            n_out_vld = 1'b1;
        end else if (o_out.ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_vld    <= 1'b0;
            r_count     <= '0;
            r_tick      <= 32'd0;
            r_elr       <= 16'd4096;
            r_estdp     <= 16'd4096;
            r_etrace    <= 16'd4096;
            r_ebcm      <= 16'd0;
            r_out_vld   <= 1'b0;
            r_lr_gain   <= 16'd8192;
            r_step      <= 13'd410;
            r_recovery  <= 13'd41;
            r_stdp_gain <= 16'd6144;
            r_elig_gain <= 16'd6144;
            r_bcm_gain  <= 16'd410;
            r_threshold <= 13'd1229;
            r_decay     <= 13'd3891;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= n_rd_vld;
            r_count   <= n_count;
            r_tick    <= n_tick;
            r_elr     <= n_elr;
            r_estdp   <= n_estdp;
            r_etrace  <= n_etrace;
            r_ebcm    <= n_ebcm;
            r_out_vld <= n_out_vld;
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (t_reg'(i_cfg.index))
                    REG_LR_GAIN:   r_lr_gain   <= i_cfg.data;
                    REG_HAB_STEP:  r_step      <= i_cfg.data[12:0];
                    REG_RECOVERY:  r_recovery  <= i_cfg.data[12:0];
                    REG_STDP_GAIN: r_stdp_gain <= i_cfg.data;
                    REG_ELIG_GAIN: r_elig_gain <= i_cfg.data;
                    REG_BCM_GAIN:  r_bcm_gain  <= i_cfg.data;
                    REG_THRESHOLD: r_threshold <= i_cfg.data[12:0];
                    REG_DECAY:     r_decay     <= i_cfg.data[12:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= t_cmd'(i_in.cmd);
            r_key  <= i_in.source_key;
            r_sval <= i_in.signed_value;
            r_dt   <= i_in.delta_time;
        end
        r_idx     <= n_idx;
        r_rd_idx  <= n_rd_idx;
        r_found   <= n_found;
        r_fidx    <= n_fidx;
        r_fhab    <= n_fhab;
        r_flast   <= n_flast;
        r_minidx  <= n_minidx;
        r_minlast <= n_minlast;
        r_drop    <= n_drop;
        r_tidx    <= n_tidx;
        r_tnew    <= n_tnew;
        r_thab    <= n_thab;
        r_eff     <= n_eff;
        r_boost   <= n_boost;
        r_k       <= n_k;
        if (load_out) begin
            r_o_lr    <= r_elr;
            r_o_stdp  <= r_estdp;
            r_o_trace <= r_etrace;
            r_o_bcm   <= r_ebcm;
            r_o_hab   <= ((r_cmd == CMD_SURPRISE) || r_found) ? r_fhab : 13'd0;
            r_o_eff   <= r_eff;
            r_o_boost <= r_boost;
            r_o_known <= (r_cmd == CMD_SURPRISE) ? !r_tnew : r_found;
            r_o_count <= 7'(r_count);
        end
    end

endmodule

// ===== verif/testbench.sv =====
module testbench;
    import hsgt_pkg::*;

    // The watchdog ends the run after this many cycles without a single transaction
    // on any channel. It must cover the slowest transaction, and the receiver's longest
    // stall, the sender's longest gap and a drain pause on top.
    localparam int IdleLimit  = 4000;
    localparam int Depth      = 64;
    localparam int StaleTicks = 10;
    localparam int PoolSize   = 72;

    // One expected result, in the order of the output channel's fields.
    typedef struct {
        logic [15:0] lr;
        logic [15:0] stdp;
        logic [15:0] trace;
        logic [15:0] bcm;
        logic [12:0] hab;
        logic [12:0] eff;
        logic        boosted;
        logic        known;
        logic [6:0]  count;
    } t_gain_result;

    logic i_clk;
    logic i_rst_n;

    hsgt_in_if  in_if ();
    hsgt_out_if out_if ();
    hsgt_cfg_if cfg_if ();

    habituating_surprise_gain_table_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Shadow copy of the table, the effects and the registers.
    logic [31:0] tbl_key   [Depth];
    logic [12:0] tbl_hab   [Depth];
    logic [31:0] tbl_last  [Depth];
    int          tbl_count;
    logic [31:0] tick_count;
    logic [15:0] fx_lr, fx_stdp, fx_trace, fx_bcm;
    logic [15:0] gain_lr, gain_stdp, gain_elig, gain_bcm;
    logic [12:0] hab_step, recovery, threshold, decay;

    t_gain_result pending_results[$];
    logic [31:0]  key_pool[PoolSize];
    int           fail_count = 0;
    bit           idle_on;
    int           quiet_cycles = 0;
    int           out_stall = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [15:0] sat16(longint v);
        if (v < 0) begin
            return 16'd0;
        end
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [12:0] sat_hab(longint v);
        return (v > 4096) ? 13'd4096 : v[12:0];
    endfunction

    function automatic longint round_q12(longint a, longint b);
        return (a * b + 2048) >>> 12;
    endfunction

    // A boosted multiplier is 1 + e * (g - 1), written as e * g + (1 - e).
    function automatic logic [15:0] boost_mult(longint e, longint g);
        return sat16((e * g + (4096 - e) * 4096 + 2048) >>> 12);
    endfunction

    // The deviation from 1.0 is scaled by the decay factor; the shift rounds toward
    // minus infinity, so negative deviations round the same way as positive ones.
    function automatic logic [15:0] decay_mult(logic [15:0] m);
        longint dev;
        dev = longint'(m) - 4096;
        return sat16(4096 + ((dev * longint'(decay) + 2048) >>> 12));
    endfunction

    function automatic int lookup_source(logic [31:0] key);
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_key[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    // A new source takes the next free entry, or on a full table the entry seen
    // longest ago, the lowest index winning a tie.
    function automatic int insert_source(logic [31:0] key);
        int idx;
        if (tbl_count >= Depth) begin
            idx = 0;
            for (int i = 1; i < Depth; i++) begin
                if (tbl_last[i] < tbl_last[idx]) begin
                    idx = i;
                end
            end
        end else begin
            idx = tbl_count;
            tbl_count++;
        end
        tbl_key[idx]  = key;
        tbl_hab[idx]  = 13'd0;
        tbl_last[idx] = tick_count;
        return idx;
    endfunction

    function automatic void reset_shadow();
        tbl_count  = 0;
        tick_count = 32'd0;
        fx_lr      = 16'd4096;
        fx_stdp    = 16'd4096;
        fx_trace   = 16'd4096;
        fx_bcm     = 16'd0;
        gain_lr    = 16'd8192;
        hab_step   = 13'd410;
        recovery   = 13'd41;
        gain_stdp  = 16'd6144;
        gain_elig  = 16'd6144;
        gain_bcm   = 16'd410;
        threshold  = 13'd1229;
        decay      = 13'd3891;
    endfunction

    function automatic void apply_register(t_reg idx, logic [15:0] value);
        case (idx)
            REG_LR_GAIN:   gain_lr   = value;
            REG_HAB_STEP:  hab_step  = value[12:0];
            REG_RECOVERY:  recovery  = value[12:0];
            REG_STDP_GAIN: gain_stdp = value;
            REG_ELIG_GAIN: gain_elig = value;
            REG_BCM_GAIN:  gain_bcm  = value;
            REG_THRESHOLD: threshold = value[12:0];
            REG_DECAY:     decay     = value[12:0];
            default: ;
        endcase
    endfunction

    // Works out the result of one transaction and moves the shadow state on.
    function automatic t_gain_result predict_gain_step(t_cmd cmd, logic [31:0] key,
                                                       logic signed [15:0] sval,
                                                       logic [15:0] dt);
        t_gain_result r;
        int     found;
        int     idx;
        longint level;
        longint eff;
        longint drop;
        longint mag;
        found     = lookup_source(key);
        eff       = 0;
        r.boosted = 1'b0;
        r.known   = (found >= 0);
        case (cmd)
            CMD_SURPRISE: begin
                level = (sval < 0) ? 0 : ((sval > 4096) ? 4096 : longint'(sval));
                idx   = (found >= 0) ? found : insert_source(key);
                tbl_last[idx] = tick_count;
                eff   = round_q12(level, 4096 - longint'(tbl_hab[idx]));
                tbl_hab[idx] = sat_hab(longint'(tbl_hab[idx]) + longint'(hab_step));
                if (eff >= longint'(threshold)) begin
                    fx_lr     = boost_mult(eff, gain_lr);
                    fx_stdp   = boost_mult(eff, gain_stdp);
                    fx_trace  = boost_mult(eff, gain_elig);
                    fx_bcm    = sat16(round_q12(eff, gain_bcm));
                    r.boosted = 1'b1;
                end
            end
            CMD_LEARN: begin
                if (found >= 0) begin
                    mag = (sval < 0) ? -longint'(sval) : longint'(sval);
                    tbl_hab[found] = sat_hab(longint'(tbl_hab[found])
                                             + round_q12(mag, hab_step));
                end
            end
            CMD_TICK: begin
                if (dt != 16'd0) begin
                    drop = (longint'(recovery) * longint'(dt) + 128) >>> 8;
                    for (int i = 0; i < tbl_count; i++) begin
                        if (32'(tick_count - tbl_last[i]) > StaleTicks) begin
                            tbl_hab[i] = (longint'(tbl_hab[i]) > drop)
                                       ? 13'(longint'(tbl_hab[i]) - drop) : 13'd0;
                        end
                    end
                    fx_lr      = decay_mult(fx_lr);
                    fx_stdp    = decay_mult(fx_stdp);
                    fx_trace   = decay_mult(fx_trace);
                    fx_bcm     = sat16(round_q12(fx_bcm, decay));
                    tick_count = tick_count + 32'd1;
                end
            end
            default: ;
        endcase
        found   = lookup_source(key);
        r.hab   = (found >= 0) ? tbl_hab[found] : 13'd0;
        r.eff   = eff[12:0];
        r.lr    = fx_lr;
        r.stdp  = fx_stdp;
        r.trace = fx_trace;
        r.bcm   = fx_bcm;
        r.count = 7'(tbl_count);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch in %s: got %0d, expected %0d", what, got, want);
        fail_count++;
    endtask

    // Offers one transaction on the input channel and records its expected result
    // once it is accepted. The valid is left high so that a following transaction
    // can follow on at once; a gap lowers it first.
    task automatic send_item(t_cmd cmd, logic [31:0] key, logic signed [15:0] sval,
                             logic [15:0] dt);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.cmd          <= cmd;
        in_if.source_key   <= key;
        in_if.signed_value <= sval;
        in_if.delta_time   <= dt;
        do begin
            @(posedge i_clk);
        end while (!in_if.ready);
        pending_results.push_back(predict_gain_step(cmd, key, sval, dt));
    endtask

    // Stops sending and waits until every expected result has come back, then pauses
    // so that the sequencer is surely back at rest.
    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_register(t_reg idx, logic [15:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do begin
            @(posedge i_clk);
        end while (!cfg_if.ready);
        apply_register(idx, value);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Picks a register value: mostly within the documented range, now and then
    // the extremes or a value with the upper bits set, which the block masks.
    function automatic logic [15:0] pick_register_value(t_reg idx);
        bit narrow;
        int pick;
        narrow = (idx == REG_HAB_STEP || idx == REG_RECOVERY
                  || idx == REG_THRESHOLD || idx == REG_DECAY);
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return 16'd0;
        end else if (pick == 1) begin
            return narrow ? 16'd4096 : 16'hFFFF;
        end else if (pick == 2) begin
            return 16'($urandom());
        end else if (narrow) begin
            return (idx == REG_THRESHOLD) ? 16'($urandom_range(0, 2500))
                                          : 16'($urandom_range(0, 4096));
        end
        return 16'($urandom_range(0, 20000));
    endfunction

    task automatic write_all_registers();
        for (int i = 0; i < 8; i++) begin
            write_register(t_reg'(i), pick_register_value(t_reg'(i)));
        end
    endtask

    // One random transaction. Most keys come from a pool a little larger than the
    // table, so that sources recur, the table fills and old entries get evicted.
    task automatic send_random_item();
        t_cmd        cmd;
        logic [31:0] key;
        logic [15:0] sval;
        logic [15:0] dt;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            cmd = CMD_SURPRISE;
        end else if (pick < 60) begin
            cmd = CMD_LEARN;
        end else if (pick < 80) begin
            cmd = CMD_TICK;
        end else begin
            cmd = CMD_QUERY;
        end
        key  = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, PoolSize - 1)]
                                          : 32'($urandom());
        sval = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                           : 16'($urandom_range(0, 4200));
        pick = $urandom_range(0, 9);
        dt   = (pick == 0) ? 16'd0
             : (pick == 1) ? 16'($urandom()) : 16'($urandom_range(1, 1024));
        send_item(cmd, key, sval, dt);
    endtask

    // Every command on the reset settings, with levels and weight changes at the
    // ends of their range, an unknown source and a tick of zero length.
    task automatic test_commands_at_reset();
        send_item(CMD_QUERY, 32'h0000_0000, 16'sd0, 16'd0);
        send_item(CMD_LEARN, 32'hDEAD_BEEF, 16'sd4096, 16'd0);
        send_item(CMD_SURPRISE, 32'hFFFF_FFFF, 16'sd4096, 16'd0);
        send_item(CMD_SURPRISE, 32'hFFFF_FFFF, 16'sh7FFF, 16'd0);
        send_item(CMD_SURPRISE, 32'h0000_0000, -16'sd32768, 16'hFFFF);
        send_item(CMD_LEARN, 32'hFFFF_FFFF, -16'sd32768, 16'd0);
        send_item(CMD_LEARN, 32'h0000_0000, 16'sh7FFF, 16'd0);
        send_item(CMD_QUERY, 32'hFFFF_FFFF, 16'sh7FFF, 16'hFFFF);
        send_item(CMD_TICK, 32'h0000_0000, 16'sd0, 16'd0);
        send_item(CMD_TICK, 32'h1234_5678, 16'sd0, 16'hFFFF);
        drain_results();
    endtask

    // A source left alone for more than the stale limit recovers on later ticks.
    task automatic test_stale_recovery();
        send_item(CMD_SURPRISE, 32'h0BAD_CAFE, 16'sd3000, 16'd0);
        for (int i = 0; i < StaleTicks + 3; i++) begin
            send_item(CMD_TICK, 32'h0BAD_CAFE, 16'sd0, 16'd256);
        end
        drain_results();
    endtask

    // Registers at both ends: a step above one saturates the habituation, a
    // threshold above one never boosts, a decay above one widens the deviation.
    task automatic test_register_extremes();
        for (int i = 0; i < 8; i++) begin
            write_register(t_reg'(i), 16'hFFFF);
        end
        send_item(CMD_SURPRISE, 32'hA5A5_5A5A, 16'sd4096, 16'd0);
        send_item(CMD_TICK, 32'hA5A5_5A5A, 16'sd0, 16'd512);
        drain_results();
        write_register(REG_THRESHOLD, 16'd0);
        write_register(REG_DECAY, 16'd4096);
        send_item(CMD_SURPRISE, 32'h5A5A_A5A5, 16'sd2048, 16'd0);
        send_item(CMD_TICK, 32'h5A5A_A5A5, 16'sd0, 16'd1);
        drain_results();
        for (int i = 0; i < 8; i++) begin
            write_register(t_reg'(i), 16'd0);
        end
        send_item(CMD_SURPRISE, 32'h0000_0001, 16'sd4096, 16'd0);
        send_item(CMD_TICK, 32'h0000_0001, 16'sd0, 16'd100);
        send_item(CMD_LEARN, 32'h0000_0001, 16'sd4096, 16'd0);
        drain_results();
    endtask

    // Random phases, each on fresh register settings. Idling stops in the final
    // phase so that the block also runs back to back.
    task automatic test_random_traffic();
        for (int phase = 0; phase < 5; phase++) begin
            write_all_registers();
            idle_on = (phase < 4);
            for (int n = 0; n < 150; n++) begin
                send_random_item();
            end
            drain_results();
        end
    endtask

    // Receiver: the ready stalls in random bursts while idling is on.
    always @(posedge i_clk) begin
        if (out_stall > 0) begin
            out_stall--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0) begin
                out_stall = $urandom_range(1, 11);
            end
        end
    end

    // Each accepted result is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_gain_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result count", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (out_if.learn_rate_gain !== want.lr)
                    report_mismatch("learn_rate_gain", out_if.learn_rate_gain, want.lr);
                if (out_if.timing_window_gain !== want.stdp)
                    report_mismatch("timing_window_gain", out_if.timing_window_gain,
                                    want.stdp);
                if (out_if.trace_multiplier !== want.trace)
                    report_mismatch("trace_multiplier", out_if.trace_multiplier,
                                    want.trace);
                if (out_if.bcm_offset !== want.bcm)
                    report_mismatch("bcm_offset", out_if.bcm_offset, want.bcm);
                if (out_if.source_habituation !== want.hab)
                    report_mismatch("source_habituation", out_if.source_habituation,
                                    want.hab);
                if (out_if.effective_level !== want.eff)
                    report_mismatch("effective_level", out_if.effective_level, want.eff);
                if (out_if.boosted !== want.boosted)
                    report_mismatch("boosted", out_if.boosted, want.boosted);
                if (out_if.source_known !== want.known)
                    report_mismatch("source_known", out_if.source_known, want.known);
                if (out_if.tracked_count !== want.count)
                    report_mismatch("tracked_count", out_if.tracked_count, want.count);
            end
        end
    end

    // Watchdog: counts cycles in which no channel completes a transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
            || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= IdleLimit) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        idle_on      = 1'b1;
        reset_shadow();
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < PoolSize; i++) begin
            key_pool[i] = $urandom();
        end
        i_rst_n             <= 1'b0;
        in_if.valid         <= 1'b0;
        in_if.cmd           <= CMD_QUERY;
        in_if.source_key    <= 32'd0;
        in_if.signed_value  <= 16'sd0;
        in_if.delta_time    <= 16'd0;
        cfg_if.valid        <= 1'b0;
        cfg_if.index        <= REG_LR_GAIN;
        cfg_if.data         <= 16'd0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_commands_at_reset();
        test_stale_recovery();
        test_register_extremes();
        test_random_traffic();

        drain_results();
        repeat (80) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/hsgt_pkg.sv
hw/rtl/hsgt_if.sv
hw/rtl/hsgt_mul.sv
hw/rtl/hsgt_table.sv
hw/rtl/habituating_surprise_gain_table_top.sv
verif/testbench.sv
